// ----- design/pfd_pkg.sv -----
package pfd_pkg;

	// signature bytes 'P', 'a', 'V', 'E'
	localparam logic [7:0] SIG_P = 8'h50;
	localparam logic [7:0] SIG_A = 8'h61;
	localparam logic [7:0] SIG_V = 8'h56;
	localparam logic [7:0] SIG_E = 8'h45;

	// frame offsets of the size fields and the smallest legal header
	localparam logic [16:0] OFF_SIG_END = 17'd4;
	localparam logic [16:0] OFF_HDR_LO  = 17'd6;
	localparam logic [16:0] OFF_HDR_HI  = 17'd7;
	localparam logic [16:0] OFF_PAY_LO  = 17'd8;
	localparam logic [16:0] OFF_PAY_HI  = 17'd9;
	localparam logic [15:0] HDR_MIN     = 16'd10;

	// depth of the queue between front and back
	localparam int QDEPTH = 8;
	localparam int QAW    = $clog2(QDEPTH);

	typedef enum logic {
		KIND_DATA = 1'b0,
		KIND_SIG  = 1'b1
	} kind_t;

	// classified request handed from front to back
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} entry_t;

	// queue status seen by the input handshake and the back
	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	function automatic logic [7:0] sig_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0: b = SIG_P;
			2'd1: b = SIG_A;
			2'd2: b = SIG_V;
			2'd3: b = SIG_E;
			default: b = SIG_P;
		endcase
		return b;
	endfunction

endpackage

// ----- design/pave_frame_deframer.sv -----
// channel   direction  handshake                 fields
// input     in         push / full               stream_byte[7:0]
// result    out        empty / pop               frame_byte[7:0], frame_first, frame_last
//
// one byte request can be taken every cycle while full is low; a data byte inside
// a frame passes through a queue entry and then the registered output slot.
// a completed signature makes four results, emitted one per cycle by the back
// end from a single queue entry while pop is high; the eight-entry queue absorbs
// that burst and full rises only when the receiver stalls. bytes outside a frame
// make no result. reset clears parser state, queue pointers and the output slot at once.
module pave_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] stream_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] frame_byte,
	output logic       frame_first,
	output logic       frame_last
);

	pfd_pkg::entry_t wr_entry;
	pfd_pkg::entry_t rd_entry;
	pfd_pkg::qstat_t stat;
	logic            wr_en;
	logic            rd_en;
	logic            accept;

	// an input request is taken whenever the queue has room
	assign full   = stat.full;
	assign accept = push && !stat.full;

	// front: signature hunt and frame length tracking
	pfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.stream_byte (stream_byte),
		.wr_en       (wr_en),
		.wr_entry    (wr_entry)
	);

	// queue between front and back
	pfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.rd_entry (rd_entry),
		.stat     (stat)
	);

	// back: signature expansion and output slot
	pfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_entry    (rd_entry),
		.stat        (stat),
		.rd_en       (rd_en),
		.pop         (pop),
		.empty       (empty),
		.frame_byte  (frame_byte),
		.frame_first (frame_first),
		.frame_last  (frame_last)
	);

endmodule

// ----- design/pfd_front.sv -----
module pfd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       stream_byte,
	output logic             wr_en,
	output pfd_pkg::entry_t  wr_entry
);

	logic [1:0]  matched_q;
	logic        in_frame_q;
	logic [16:0] offset_q;
	logic [15:0] header_q;
	logic [15:0] payload_q;

	logic [1:0]  matched_d;
	logic        in_frame_d;
	logic [16:0] offset_d;
	logic [15:0] header_d;
	logic [15:0] payload_d;

	logic        sig_hit;
	logic [15:0] header_hi;
	logic [15:0] payload_sel;
	logic [16:0] len_sum;
	logic [17:0] off_plus1;
	logic        last;

	// size fields as seen at this byte
	assign header_hi   = {stream_byte, header_q[7:0]};
	assign payload_sel = (offset_q == pfd_pkg::OFF_PAY_HI) ? {stream_byte, payload_q[7:0]}
	                                                       : payload_q;
	assign len_sum     = {1'b0, header_q} + {1'b0, payload_sel};
	assign off_plus1   = {1'b0, offset_q} + 18'd1;

	// end of frame: short header or total length reached
	always_comb begin
		last = 1'b0;
		if (offset_q == pfd_pkg::OFF_HDR_HI) begin
			last = (header_hi < pfd_pkg::HDR_MIN);
		end else if (offset_q >= pfd_pkg::OFF_PAY_HI) begin
			last = ({1'b0, len_sum} == off_plus1);
		end
	end

	assign sig_hit = (stream_byte == pfd_pkg::sig_byte(matched_q));

	// next state and classified request
	always_comb begin
		matched_d  = matched_q;
		in_frame_d = in_frame_q;
		offset_d   = offset_q;
		header_d   = header_q;
		payload_d  = payload_q;
		wr_en      = 1'b0;
		wr_entry   = '{kind: pfd_pkg::KIND_DATA, data: stream_byte, last: 1'b0};
		if (accept) begin
			if (!in_frame_q) begin
				if (sig_hit && matched_q == 2'd3) begin
					wr_en         = 1'b1;
					wr_entry.kind = pfd_pkg::KIND_SIG;
					matched_d     = 2'd0;
					in_frame_d    = 1'b1;
					offset_d      = pfd_pkg::OFF_SIG_END;
					header_d      = '0;
					payload_d     = '0;
				end else if (sig_hit) begin
					matched_d = matched_q + 2'd1;
				end else begin
					matched_d = (stream_byte == pfd_pkg::SIG_P) ? 2'd1 : 2'd0;
				end
			end else begin
				wr_en         = 1'b1;
				wr_entry.last = last;
				if (offset_q == pfd_pkg::OFF_HDR_LO) begin
					header_d = {8'd0, stream_byte};
				end else if (offset_q == pfd_pkg::OFF_HDR_HI) begin
					header_d = header_hi;
				end else if (offset_q == pfd_pkg::OFF_PAY_LO) begin
					payload_d = {8'd0, stream_byte};
				end else if (offset_q == pfd_pkg::OFF_PAY_HI) begin
					payload_d = payload_sel;
				end
				if (last) begin
					in_frame_d = 1'b0;
					offset_d   = '0;
					matched_d  = 2'd0;
				end else begin
					offset_d = offset_q + 17'd1;
				end
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matched_q  <= '0;
			in_frame_q <= 1'b0;
			offset_q   <= '0;
			header_q   <= '0;
			payload_q  <= '0;
		end else begin
			matched_q  <= matched_d;
			in_frame_q <= in_frame_d;
			offset_q   <= offset_d;
			header_q   <= header_d;
			payload_q  <= payload_d;
		end
	end

`ifndef SYNTHESIS
	a_frame_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (matched_q == 2'd0))
		else $error("partial signature count kept inside a frame");
	a_frame_offset: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (offset_q >= pfd_pkg::OFF_SIG_END))
		else $error("frame offset below end of signature");
`endif

endmodule

// ----- design/pfd_queue.sv -----
module pfd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  pfd_pkg::entry_t  wr_entry,
	input  logic             rd_en,
	output pfd_pkg::entry_t  rd_entry,
	output pfd_pkg::qstat_t  stat
);

	pfd_pkg::entry_t mem_q [pfd_pkg::QDEPTH];

	logic [pfd_pkg::QAW-1:0] wr_ptr_q;
	logic [pfd_pkg::QAW-1:0] rd_ptr_q;
	logic [pfd_pkg::QAW:0]   count_q;
	logic                    do_wr;
	logic                    do_rd;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (pfd_pkg::QAW + 1)'(pfd_pkg::QDEPTH));
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_entry   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_queue_count: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && stat.full && !do_rd) |=> (count_q == $past(count_q)))
		else $error("queue count moved on write while full");
`endif

endmodule

// ----- design/pfd_back.sv -----
module pfd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  pfd_pkg::entry_t  rd_entry,
	input  pfd_pkg::qstat_t  stat,
	output logic             rd_en,
	input  logic             pop,
	output logic             empty,
	output logic [7:0]       frame_byte,
	output logic             frame_first,
	output logic             frame_last
);

	logic       valid_q;
	logic [1:0] sig_idx_q;
	logic [7:0] byte_q;
	logic       first_q;
	logic       last_q;
	logic       load;

	assign empty       = !valid_q;
	assign frame_byte  = byte_q;
	assign frame_first = first_q;
	assign frame_last  = last_q;

	// output slot free or being drained this cycle
	assign load  = !valid_q || pop;
	assign rd_en = load && (sig_idx_q == 2'd0) && !stat.empty;

	// output control: valid and signature expansion index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			sig_idx_q <= '0;
		end else if (load) begin
			if (sig_idx_q != 2'd0) begin
				valid_q   <= 1'b1;
				sig_idx_q <= sig_idx_q + 2'd1;
			end else if (!stat.empty) begin
				valid_q   <= 1'b1;
				sig_idx_q <= (rd_entry.kind == pfd_pkg::KIND_SIG) ? 2'd1 : 2'd0;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (sig_idx_q != 2'd0) begin
				byte_q  <= pfd_pkg::sig_byte(sig_idx_q);
				first_q <= 1'b0;
				last_q  <= 1'b0;
			end else if (!stat.empty) begin
				if (rd_entry.kind == pfd_pkg::KIND_SIG) begin
					byte_q  <= pfd_pkg::SIG_P;
					first_q <= 1'b1;
					last_q  <= 1'b0;
				end else begin
					byte_q  <= rd_entry.data;
					first_q <= 1'b0;
					last_q  <= rd_entry.last;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_expand_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(sig_idx_q != 2'd0) |-> valid_q)
		else $error("signature expansion without a result held");
	a_first_is_p: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && first_q) |-> (byte_q == pfd_pkg::SIG_P && !last_q))
		else $error("frame start not on signature byte");
`endif

endmodule

// ----- tb/pave_frame_deframer_tb.sv -----
module pave_frame_deframer_tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [7:0] stream_byte = 8'h00;
	logic pop = 1'b0;
	logic full;
	logic empty;
	logic [7:0] frame_byte;
	logic frame_first;
	logic frame_last;

	typedef struct {
		logic [7:0] data;
		logic       first;
		logic       last;
	} frame_out_t;

	localparam logic [7:0] SIG_SEQ [4] = '{pfd_pkg::SIG_P, pfd_pkg::SIG_A,
		pfd_pkg::SIG_V, pfd_pkg::SIG_E};

	// expected frame bytes, oldest first
	frame_out_t frame_exp_q [$];

	// mirror of the parser state
	logic [1:0]  match_cnt = 2'd0;
	logic        framing = 1'b0;
	logic [16:0] frame_pos = 17'd0;
	logic [15:0] hdr_len = 16'd0;
	logic [15:0] pay_len = 16'd0;

	int send_gap_max = 18;
	int take_gap_max = 18;
	int sink_hold = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int bytes_checked = 0;
	int mismatches = 0;

	pave_frame_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.stream_byte(stream_byte),
		.empty(empty),
		.pop(pop),
		.frame_byte(frame_byte),
		.frame_first(frame_first),
		.frame_last(frame_last)
	);

	always #5 clk = ~clk;

	// idle cycles before the next request on either side
	function automatic int draw_gap(input int limit);
		if (limit == 0)
			return 0;
		return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, limit)) : 0;
	endfunction

	function automatic void expect_byte(input logic [7:0] data, input logic first,
			input logic last);
		frame_out_t item;
		item.data = data;
		item.first = first;
		item.last = last;
		frame_exp_q.push_back(item);
	endfunction

	// hunt for the signature or pass the frame byte on, tracking the size fields
	function automatic void deframe_predict(input logic [7:0] b);
		logic closes;
		int frame_end;
		closes = 1'b0;
		frame_end = int'(hdr_len) + int'(pay_len) - 1;
		if (!framing) begin
			if (b == SIG_SEQ[match_cnt]) begin
				if (match_cnt == 2'd3) begin
					expect_byte(pfd_pkg::SIG_P, 1'b1, 1'b0);
					expect_byte(pfd_pkg::SIG_A, 1'b0, 1'b0);
					expect_byte(pfd_pkg::SIG_V, 1'b0, 1'b0);
					expect_byte(pfd_pkg::SIG_E, 1'b0, 1'b0);
					match_cnt = 2'd0;
					framing = 1'b1;
					frame_pos = pfd_pkg::OFF_SIG_END;
					hdr_len = 16'd0;
					pay_len = 16'd0;
				end else begin
					match_cnt = match_cnt + 2'd1;
				end
			end else begin
				match_cnt = (b == pfd_pkg::SIG_P) ? 2'd1 : 2'd0;
			end
			return;
		end
		case (frame_pos)
			pfd_pkg::OFF_HDR_LO: hdr_len = {8'h00, b};
			pfd_pkg::OFF_HDR_HI: begin
				hdr_len[15:8] = b;
				closes = (hdr_len < pfd_pkg::HDR_MIN);
			end
			pfd_pkg::OFF_PAY_LO: pay_len = {8'h00, b};
			pfd_pkg::OFF_PAY_HI: begin
				pay_len[15:8] = b;
				closes = (int'(hdr_len) + int'(pay_len) - 1 == int'(frame_pos));
			end
			default: closes = (frame_pos > pfd_pkg::OFF_PAY_HI) &&
				(frame_end == int'(frame_pos));
		endcase
		expect_byte(b, 1'b0, closes);
		if (closes) begin
			framing = 1'b0;
			frame_pos = 17'd0;
			match_cnt = 2'd0;
		end else begin
			frame_pos = frame_pos + 17'd1;
		end
	endfunction

	// offer one stream byte, keeping push high when no gap is drawn
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = draw_gap(send_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (full);
		deframe_predict(b);
		bytes_sent++;
	endtask

	// signature, two filler bytes, sizes, then header rest and payload
	task automatic send_frame(input logic [15:0] hdr, input logic [15:0] pay,
			input bit plant_sig);
		int body;
		frames_sent++;
		for (int i = 0; i < 4; i++)
			send_byte(SIG_SEQ[i]);
		send_byte(8'($urandom_range(0, 255)));
		send_byte(8'($urandom_range(0, 255)));
		send_byte(hdr[7:0]);
		send_byte(hdr[15:8]);
		if (hdr >= pfd_pkg::HDR_MIN) begin
			send_byte(pay[7:0]);
			send_byte(pay[15:8]);
			body = int'(hdr) + int'(pay) - 10;
			for (int i = 0; i < body; i++) begin
				if (plant_sig && i < 4)
					send_byte(SIG_SEQ[i]);
				else
					send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// result side: random stalls, one long hold when asked, field checks
	initial begin : frame_sink
		int gap;
		frame_out_t want;
		wait (arst_n);
		forever begin
			gap = draw_gap(take_gap_max);
			if (sink_hold > 0) begin
				gap = sink_hold;
				sink_hold = 0;
			end
			@(negedge clk);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (frame_exp_q.size() == 0) begin
				$error("unexpected frame byte %02h (first %0b last %0b)",
					frame_byte, frame_first, frame_last);
				mismatches++;
			end else begin
				want = frame_exp_q.pop_front();
				bytes_checked++;
				if (frame_byte !== want.data) begin
					$error("frame_byte: expected %02h, got %02h", want.data, frame_byte);
					mismatches++;
				end
				if (frame_first !== want.first) begin
					$error("frame_first: expected %0b, got %0b", want.first, frame_first);
					mismatches++;
				end
				if (frame_last !== want.last) begin
					$error("frame_last: expected %0b, got %0b", want.last, frame_last);
					mismatches++;
				end
			end
		end
	end

	// partial signatures broken by other bytes and by a repeated 'P'
	task automatic test_broken_signature();
		send_byte(pfd_pkg::SIG_P);
		send_byte(pfd_pkg::SIG_A);
		send_byte(8'h00);
		send_byte(pfd_pkg::SIG_P);
		send_byte(pfd_pkg::SIG_A);
		send_byte(pfd_pkg::SIG_V);
		send_byte(8'hFF);
		send_byte(pfd_pkg::SIG_P);
		send_byte(pfd_pkg::SIG_P);
		// shortest legal frame: header ten, no payload
		send_frame(16'd10, 16'd0, 1'b0);
	endtask

	// header sizes under ten close the frame on the size byte
	task automatic test_short_header();
		send_frame(16'd9, 16'd0, 1'b0);
		send_frame(16'd0, 16'hFFFF, 1'b0);
	endtask

	// a signature inside the payload is plain data; next frame follows at once
	task automatic test_embedded_signature();
		send_frame(16'd10, 16'd8, 1'b1);
		send_frame(16'd12, 16'd1, 1'b0);
	endtask

	// a longer payload sent with short gaps
	task automatic test_long_payload();
		send_gap_max = 2;
		send_frame(16'd10, 16'd24, 1'b0);
		send_gap_max = 18;
	endtask

	// receiver holds off while the sender keeps pushing until full rises
	task automatic test_backpressure();
		send_gap_max = 0;
		sink_hold = 80;
		send_frame(16'd10, 16'd6, 1'b0);
		send_frame(16'd11, 16'd3, 1'b1);
		send_frame(16'd5, 16'd0, 1'b0);
		send_gap_max = 18;
	endtask

	// mostly well-formed frames of small random size, with noise in between
	task automatic test_random_stream();
		int start;
		int n;
		start = bytes_sent;
		while (bytes_sent - start < 32) begin
			case ($urandom_range(0, 9))
				0: begin
					n = $urandom_range(1, 6);
					repeat (n) send_byte(8'($urandom_range(0, 255)));
				end
				1: begin
					send_byte(pfd_pkg::SIG_P);
					if ($urandom_range(0, 1)) begin
						send_byte(pfd_pkg::SIG_A);
						if ($urandom_range(0, 1))
							send_byte(pfd_pkg::SIG_V);
					end
					send_byte(8'($urandom_range(0, 255)));
				end
				2: send_frame(16'($urandom_range(0, 9)), 16'($urandom_range(0, 65535)),
					1'b0);
				default: send_frame(16'($urandom_range(10, 16)), 16'($urandom_range(0, 10)),
					$urandom_range(0, 3) == 0);
			endcase
			if ($urandom_range(0, 5) == 0) begin
				send_gap_max = $urandom_range(0, 1) ? 18 : 0;
				take_gap_max = $urandom_range(0, 1) ? 18 : 0;
			end
		end
		send_gap_max = 18;
		take_gap_max = 18;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_broken_signature();
		test_short_header();
		test_embedded_signature();
		test_long_payload();
		test_backpressure();
		test_random_stream();

		@(negedge clk);
		push <= 1'b0;
		while (frame_exp_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d stream bytes holding %0d framed records", bytes_sent, frames_sent);
		$display("checked %0d frame bytes, %0d mismatches", bytes_checked, mismatches);
		if (mismatches == 0 && frame_exp_q.size() == 0) begin
			$display("pave_frame_deframer_tb passed");
		end else begin
			$display("pave_frame_deframer_tb failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("pave_frame_deframer_tb failed");
		$finish;
	end

endmodule
